// ===== design/nif_pkg.sv =====
// ----------------------------------------------------------------------------
// nif_pkg: shared types and constants for the NEC IR frame decoder
// Item modes, window register map and reset values, config and result types.
// ----------------------------------------------------------------------------
package nif_pkg;

	localparam int unsigned TickW   = 16;
	localparam int unsigned BitPosW = 6;
	localparam int unsigned FrameBits = 32;
	localparam int unsigned AddrW   = 5;
	localparam int unsigned DataW   = 32;

	typedef enum logic [1:0] {
		MODE_DATA   = 2'd0,
		MODE_LEADER = 2'd1,
		MODE_END    = 2'd2
	} mode_t;

	// register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_LEADER_MIN = 3'd0,
		REG_LEADER_MAX = 3'd1,
		REG_SPACE_MIN  = 3'd2,
		REG_SPACE_MAX  = 3'd3,
		REG_ZERO_MIN   = 3'd4,
		REG_ZERO_MAX   = 3'd5,
		REG_ONE_MIN    = 3'd6,
		REG_ONE_MAX    = 3'd7
	} reg_idx_t;

	localparam logic [TickW-1:0] LEADER_MIN_RST = 16'd8950;
	localparam logic [TickW-1:0] LEADER_MAX_RST = 16'd9050;
	localparam logic [TickW-1:0] SPACE_MIN_RST  = 16'd4400;
	localparam logic [TickW-1:0] SPACE_MAX_RST  = 16'd4600;
	localparam logic [TickW-1:0] ZERO_MIN_RST   = 16'd1100;
	localparam logic [TickW-1:0] ZERO_MAX_RST   = 16'd1400;
	localparam logic [TickW-1:0] ONE_MIN_RST    = 16'd2200;
	localparam logic [TickW-1:0] ONE_MAX_RST    = 16'd2300;

	typedef struct packed {
		logic [TickW-1:0] leader_min;
		logic [TickW-1:0] leader_max;
		logic [TickW-1:0] space_min;
		logic [TickW-1:0] space_max;
		logic [TickW-1:0] zero_min;
		logic [TickW-1:0] zero_max;
		logic [TickW-1:0] one_min;
		logic [TickW-1:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic               frame_ok;
		logic [7:0]         address;
		logic [7:0]         address_cpl;
		logic [7:0]         command;
		logic [7:0]         command_cpl;
		logic [BitPosW-1:0] bits_taken;
	} result_t;

endpackage

// ===== design/nec_ir_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder: NEC infrared frame decoder on edge intervals
// Input item: mode (data edge, leader edge, frame end) and interval in ticks.
// Output item: frame_ok flag, four bit-reversed bytes and bits_taken.
//
// Usage:
//  - Items enter on item_valid/item_ready into an input register; each one is
//    applied to the frame state from there. One item per cycle is sustained
//    while no frame-end item waits in the input register.
//  - Only a frame-end item produces a result; when it leaves the input register,
//    the result register and frame_valid load together.
//  - When frame_ready is held low with a result pending, a later frame-end
//    item waits in the input register and item_ready drops; edge items ahead
//    of it are still applied.
//  - The user must write window bounds over the APB port with no items in
//    flight (not enforced here); reset loads the default NEC timing windows.
//  - arst_n clears the frame state and both valid flags.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nif_pkg::AddrW-1:0]   paddr,
	input  logic [nif_pkg::DataW-1:0]   pwdata,
	output logic [nif_pkg::DataW-1:0]   prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  logic [1:0]                  mode,
	input  logic [nif_pkg::TickW-1:0]   interval,
	output logic                        frame_valid,
	input  logic                        frame_ready,
	output logic                        frame_ok,
	output logic [7:0]                  address,
	output logic [7:0]                  address_cpl,
	output logic [7:0]                  command,
	output logic [7:0]                  command_cpl,
	output logic [nif_pkg::BitPosW-1:0] bits_taken
);

	nif_pkg::cfg_t    cfg;
	nif_pkg::result_t result;
	nif_pkg::result_t result_q;

	logic                      valid_s1;
	logic [1:0]                mode_s1;
	logic [nif_pkg::TickW-1:0] interval_s1;
	logic                      is_end_s1;
	logic                      go_s1;
	logic                      frame_valid_q;
	logic                      load_res;

	assign pready = 1'b1;

	nif_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// a frame-end item may only leave stage 1 when the result slot is free
	assign is_end_s1  = (mode_s1 == nif_pkg::MODE_END);
	assign go_s1      = valid_s1 & (~is_end_s1 | ~frame_valid_q | frame_ready);
	assign load_res   = go_s1 & is_end_s1;
	assign item_ready = ~valid_s1 | go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			mode_s1     <= mode;
			interval_s1 <= interval;
		end
	end

	nif_frame_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (go_s1),
		.mode     (mode_s1),
		.interval (interval_s1),
		.cfg      (cfg),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= 1'b0;
		end else if (load_res) begin
			frame_valid_q <= 1'b1;
		end else if (frame_ready) begin
			frame_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			result_q <= result;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame_ok    = result_q.frame_ok;
	assign address     = result_q.address;
	assign address_cpl = result_q.address_cpl;
	assign command     = result_q.command;
	assign command_cpl = result_q.command_cpl;
	assign bits_taken  = result_q.bits_taken;

endmodule

// ===== design/nif_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// nif_cfg_regs: window configuration registers
// APB-style register file holding the eight 16-bit interval window bounds.
// ----------------------------------------------------------------------------
module nif_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nif_pkg::AddrW-1:0]   paddr,
	input  logic [nif_pkg::DataW-1:0]   pwdata,
	output logic [nif_pkg::DataW-1:0]   prdata,
	output nif_pkg::cfg_t               cfg
);

	nif_pkg::cfg_t    cfg_q;
	nif_pkg::reg_idx_t idx;
	logic [nif_pkg::TickW-1:0] wval;
	logic [nif_pkg::TickW-1:0] rval;
	logic wr_en;

	assign idx   = nif_pkg::reg_idx_t'(paddr[4:2]);
	assign wval  = pwdata[nif_pkg::TickW-1:0];
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min <= nif_pkg::LEADER_MIN_RST;
			cfg_q.leader_max <= nif_pkg::LEADER_MAX_RST;
			cfg_q.space_min  <= nif_pkg::SPACE_MIN_RST;
			cfg_q.space_max  <= nif_pkg::SPACE_MAX_RST;
			cfg_q.zero_min   <= nif_pkg::ZERO_MIN_RST;
			cfg_q.zero_max   <= nif_pkg::ZERO_MAX_RST;
			cfg_q.one_min    <= nif_pkg::ONE_MIN_RST;
			cfg_q.one_max    <= nif_pkg::ONE_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				nif_pkg::REG_LEADER_MIN: cfg_q.leader_min <= wval;
				nif_pkg::REG_LEADER_MAX: cfg_q.leader_max <= wval;
				nif_pkg::REG_SPACE_MIN:  cfg_q.space_min  <= wval;
				nif_pkg::REG_SPACE_MAX:  cfg_q.space_max  <= wval;
				nif_pkg::REG_ZERO_MIN:   cfg_q.zero_min   <= wval;
				nif_pkg::REG_ZERO_MAX:   cfg_q.zero_max   <= wval;
				nif_pkg::REG_ONE_MIN:    cfg_q.one_min    <= wval;
				nif_pkg::REG_ONE_MAX:    cfg_q.one_max    <= wval;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			nif_pkg::REG_LEADER_MIN: rval = cfg_q.leader_min;
			nif_pkg::REG_LEADER_MAX: rval = cfg_q.leader_max;
			nif_pkg::REG_SPACE_MIN:  rval = cfg_q.space_min;
			nif_pkg::REG_SPACE_MAX:  rval = cfg_q.space_max;
			nif_pkg::REG_ZERO_MIN:   rval = cfg_q.zero_min;
			nif_pkg::REG_ZERO_MAX:   rval = cfg_q.zero_max;
			nif_pkg::REG_ONE_MIN:    rval = cfg_q.one_min;
			nif_pkg::REG_ONE_MAX:    rval = cfg_q.one_max;
			default:                 rval = '0;
		endcase
	end

	assign prdata = {{(nif_pkg::DataW - nif_pkg::TickW){1'b0}}, rval};
	assign cfg    = cfg_q;

endmodule

// ===== design/nif_frame_core.sv =====
// ----------------------------------------------------------------------------
// nif_frame_core: frame state and window classification
// Holds the per-frame state, updates it for one item per cycle when step is
// high and forms the frame result from the current state.
// ----------------------------------------------------------------------------
module nif_frame_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [1:0]                  mode,
	input  logic [nif_pkg::TickW-1:0]   interval,
	input  nif_pkg::cfg_t               cfg,
	output nif_pkg::result_t            result
);

	logic [1:0]                  edge_count_q, edge_count_d, edge_inc;
	logic [nif_pkg::BitPosW-1:0] bit_pos_q, bit_pos_d;
	logic                        leader_seen_q, leader_seen_d;
	logic                        space_seen_q, space_seen_d;
	logic                        leader_taken_q, leader_taken_d;
	logic [7:0]                  shift_q [4];
	logic [7:0]                  shift_d [4];
	logic [1:0]                  sel;
	logic win_leader, win_space, win_zero, win_one;

	function automatic logic in_win(input logic [nif_pkg::TickW-1:0] v,
		input logic [nif_pkg::TickW-1:0] lo, input logic [nif_pkg::TickW-1:0] hi);
		return (v > lo) && (v < hi);
	endfunction

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	assign win_leader = in_win(interval, cfg.leader_min, cfg.leader_max);
	assign win_space  = in_win(interval, cfg.space_min, cfg.space_max);
	assign win_zero   = in_win(interval, cfg.zero_min, cfg.zero_max);
	assign win_one    = in_win(interval, cfg.one_min, cfg.one_max);
	assign edge_inc   = (edge_count_q == 2'd3) ? edge_count_q : edge_count_q + 2'd1;
	assign sel        = bit_pos_q[4:3];

	always_comb begin
		edge_count_d   = edge_count_q;
		bit_pos_d      = bit_pos_q;
		leader_seen_d  = leader_seen_q;
		space_seen_d   = space_seen_q;
		leader_taken_d = leader_taken_q;
		for (int i = 0; i < 4; i++) begin
			shift_d[i] = shift_q[i];
		end
		case (mode)
			nif_pkg::MODE_DATA: begin
				// a data edge with no counted edge leaves the frame state unchanged
				if (edge_count_q != 2'd0) begin
					edge_count_d = edge_inc;
					if (edge_inc == 2'd2 && win_space)
						space_seen_d = 1'b1;
					if (leader_seen_q && space_seen_q && edge_inc == 2'd3 &&
						bit_pos_q < nif_pkg::BitPosW'(nif_pkg::FrameBits)) begin
						// zero window wins over one; no match leaves the byte alone
						if (win_zero)
							shift_d[sel] = {shift_q[sel][6:0], 1'b0};
						else if (win_one)
							shift_d[sel] = {shift_q[sel][6:0], 1'b1};
						bit_pos_d = bit_pos_q + 1'b1;
					end
				end
			end
			nif_pkg::MODE_LEADER: begin
				if (!leader_taken_q) begin
					edge_count_d   = edge_inc;
					leader_taken_d = 1'b1;
					if (win_leader)
						leader_seen_d = 1'b1;
				end
			end
			nif_pkg::MODE_END: begin
				edge_count_d   = '0;
				bit_pos_d      = '0;
				leader_seen_d  = 1'b0;
				space_seen_d   = 1'b0;
				leader_taken_d = 1'b0;
				for (int i = 0; i < 4; i++) begin
					shift_d[i] = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q   <= '0;
			bit_pos_q      <= '0;
			leader_seen_q  <= 1'b0;
			space_seen_q   <= 1'b0;
			leader_taken_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				shift_q[i] <= '0;
			end
		end else if (step) begin
			edge_count_q   <= edge_count_d;
			bit_pos_q      <= bit_pos_d;
			leader_seen_q  <= leader_seen_d;
			space_seen_q   <= space_seen_d;
			leader_taken_q <= leader_taken_d;
			for (int i = 0; i < 4; i++) begin
				shift_q[i] <= shift_d[i];
			end
		end
	end

	assign result.frame_ok    = leader_seen_q & space_seen_q;
	assign result.address     = flip8(shift_q[0]);
	assign result.address_cpl = flip8(shift_q[1]);
	assign result.command     = flip8(shift_q[2]);
	assign result.command_cpl = flip8(shift_q[3]);
	assign result.bits_taken  = bit_pos_q;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the NEC IR frame decoder
// Sends leader, data, frame-end and unused items with random gaps in idling phases, keeps its
// own model of the frame state and window registers, and checks every frame
// result against the oldest prediction. Window sets are changed over APB
// between phases: the reset windows, random NEC-like windows, all-open,
// all-closed, overlapping bit windows and the defaults written back.
// ----------------------------------------------------------------------------
module tb_top;
	import nif_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS = 310;

	class nec_frame_tracker;
		cfg_t win;
		logic [1:0] edges;
		logic [5:0] bit_pos;
		bit leader_hit, space_hit, leader_done;
		logic [7:0] bytes [4];
		result_t frames_due [$];
		int unsigned errors;

		function new();
			win = '{LEADER_MIN_RST, LEADER_MAX_RST, SPACE_MIN_RST, SPACE_MAX_RST,
				ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST};
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			edges = '0;
			bit_pos = '0;
			leader_hit = 0;
			space_hit = 0;
			leader_done = 0;
			foreach (bytes[i]) bytes[i] = '0;
		endfunction

		function void set_window(reg_idx_t idx, logic [15:0] v);
			case (idx)
				REG_LEADER_MIN: win.leader_min = v;
				REG_LEADER_MAX: win.leader_max = v;
				REG_SPACE_MIN:  win.space_min = v;
				REG_SPACE_MAX:  win.space_max = v;
				REG_ZERO_MIN:   win.zero_min = v;
				REG_ZERO_MAX:   win.zero_max = v;
				REG_ONE_MIN:    win.one_min = v;
				REG_ONE_MAX:    win.one_max = v;
				default: ;
			endcase
		endfunction

		function bit hit(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
			return v > lo && v < hi;
		endfunction

		function logic [7:0] reverse8(logic [7:0] v);
			logic [7:0] r;
			for (int i = 0; i < 8; i++) r[i] = v[7-i];
			return r;
		endfunction

		function void take_item(logic [1:0] md, logic [15:0] ivl);
			logic [1:0] sel;
			result_t r;
			case (md)
				MODE_DATA: begin
					// a data edge before any counted edge does nothing at all
					if (edges != 0) begin
						if (edges != 2'd3) edges++;
						if (edges == 2'd2 && hit(ivl, win.space_min, win.space_max))
							space_hit = 1;
						if (leader_hit && space_hit && edges > 2'd2 && bit_pos < 32) begin
							sel = bit_pos[4:3];
							// zero window wins when both match
							if (hit(ivl, win.zero_min, win.zero_max))
								bytes[sel] = {bytes[sel][6:0], 1'b0};
							else if (hit(ivl, win.one_min, win.one_max))
								bytes[sel] = {bytes[sel][6:0], 1'b1};
							bit_pos++;
						end
					end
				end
				MODE_LEADER: begin
					if (!leader_done) begin
						if (edges != 2'd3) edges++;
						if (hit(ivl, win.leader_min, win.leader_max)) leader_hit = 1;
						leader_done = 1;
					end
				end
				MODE_END: begin
					r.frame_ok = leader_hit && space_hit;
					r.address = reverse8(bytes[0]);
					r.address_cpl = reverse8(bytes[1]);
					r.command = reverse8(bytes[2]);
					r.command_cpl = reverse8(bytes[3]);
					r.bits_taken = bit_pos;
					frames_due.push_back(r);
					clear_frame();
				end
				default: ;
			endcase
		endfunction

		function void check_frame(result_t got);
			result_t want;
			if (frames_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected frame: ok=%0b %h %h %h %h bits=%0d",
						got.frame_ok, got.address, got.address_cpl, got.command,
						got.command_cpl, got.bits_taken);
				return;
			end
			want = frames_due.pop_front();
			if (got.frame_ok !== want.frame_ok || got.address !== want.address ||
					got.address_cpl !== want.address_cpl ||
					got.command !== want.command ||
					got.command_cpl !== want.command_cpl ||
					got.bits_taken !== want.bits_taken) begin
				errors++;
				if (errors <= 10)
					$display({"frame differs: exp ok=%0b %h %h %h %h bits=%0d,",
						" got ok=%0b %h %h %h %h bits=%0d"},
						want.frame_ok, want.address, want.address_cpl, want.command,
						want.command_cpl, want.bits_taken, got.frame_ok, got.address,
						got.address_cpl, got.command, got.command_cpl, got.bits_taken);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] mode = MODE_DATA;
	logic [TickW-1:0] interval = '0;
	logic frame_valid;
	logic frame_ready = 1'b0;
	logic frame_ok;
	logic [7:0] address, address_cpl, command, command_cpl;
	logic [BitPosW-1:0] bits_taken;

	nec_frame_tracker trk = new();
	bit tx_idle = 1;
	bit rx_idle = 1;
	bit rx_hold_req = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;

	nec_ir_frame_decoder dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready),
		.mode(mode), .interval(interval),
		.frame_valid(frame_valid), .frame_ready(frame_ready),
		.frame_ok(frame_ok), .address(address), .address_cpl(address_cpl),
		.command(command), .command_cpl(command_cpl), .bits_taken(bits_taken)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (frame_valid && frame_ready) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("nec_ir_frame_decoder: mismatch");
				$finish;
			end
		end
	end

	// result side
	initial begin
		int unsigned stall;
		result_t got;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (rx_hold_req) begin
				stall = HOLD_CYCLES;
				rx_hold_req = 0;
			end else begin
				stall = rx_idle ? $urandom_range(0, 10) : 0;
			end
			if (stall != 0) begin
				frame_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			frame_ready <= 1'b1;
			do @(posedge clk); while (!frame_valid);
			got = '{frame_ok, address, address_cpl, command, command_cpl, bits_taken};
			trk.check_frame(got);
			@(negedge clk);
		end
	end

	function automatic logic [15:0] rand16();
		return 16'($urandom_range(0, 65535));
	endfunction

	// a tick strictly inside the window, or any tick if it has no interior
	function automatic logic [15:0] tick_in(logic [15:0] lo, logic [15:0] hi);
		if (int'(hi) > int'(lo) + 1)
			return 16'($urandom_range(int'(lo) + 1, int'(hi) - 1));
		return rand16();
	endfunction

	function automatic logic [15:0] bit_tick();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 42) return tick_in(trk.win.zero_min, trk.win.zero_max);
		if (r < 84) return tick_in(trk.win.one_min, trk.win.one_max);
		if (r < 92) begin
			case ($urandom_range(0, 3))
				0: return trk.win.zero_min;
				1: return trk.win.zero_max;
				2: return trk.win.one_min;
				default: return trk.win.one_max;
			endcase
		end
		return rand16();
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic [1:0] md, logic [15:0] ivl);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= md;
		interval <= ivl;
		do @(posedge clk); while (!item_ready);
		trk.take_item(md, ivl);
		if (md != MODE_UNUSED) items_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		int unsigned nbits;
		nbits = ($urandom_range(0, 99) < 80) ? 32 : $urandom_range(0, 40);
		if ($urandom_range(0, 19) != 0)
			send_item(MODE_LEADER, ($urandom_range(0, 9) == 0) ? rand16() :
				tick_in(trk.win.leader_min, trk.win.leader_max));
		if ($urandom_range(0, 19) == 0)
			send_item(MODE_LEADER, tick_in(trk.win.leader_min, trk.win.leader_max));
		send_item(MODE_DATA, ($urandom_range(0, 9) == 0) ? rand16() :
			tick_in(trk.win.space_min, trk.win.space_max));
		for (int i = 0; i < nbits; i++) begin
			if ($urandom_range(0, 39) == 0) send_item(MODE_UNUSED, rand16());
			send_item(MODE_DATA, bit_tick());
		end
		send_item(MODE_END, rand16());
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 8))
			send_item(2'($urandom_range(0, 3)), rand16());
	endtask

	task automatic run_items(int unsigned count);
		int unsigned stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 70) send_frame();
			else send_noise();
		end
	endtask

	// wait for all frames out, then let the input register empty
	task automatic settle();
		item_valid <= 1'b0;
		while (trk.frames_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_window(reg_idx_t idx, logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		trk.set_window(idx, v);
		@(negedge clk);
	endtask

	task automatic program_windows(cfg_t c);
		settle();
		write_window(REG_LEADER_MIN, c.leader_min);
		write_window(REG_LEADER_MAX, c.leader_max);
		write_window(REG_SPACE_MIN, c.space_min);
		write_window(REG_SPACE_MAX, c.space_max);
		write_window(REG_ZERO_MIN, c.zero_min);
		write_window(REG_ZERO_MAX, c.zero_max);
		write_window(REG_ONE_MIN, c.one_min);
		write_window(REG_ONE_MAX, c.one_max);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		cfg_t c;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset windows
		send_item(MODE_END, 16'hFFFF);              // empty frame
		send_item(MODE_UNUSED, 16'hFFFF);
		send_item(MODE_DATA, 16'h0000);             // no leader yet
		send_item(MODE_LEADER, LEADER_MIN_RST);     // leader on the bound: miss
		send_item(MODE_LEADER, 16'd9000);           // repeated, ignored
		send_item(MODE_DATA, 16'd4500);
		send_item(MODE_DATA, 16'd1200);
		send_item(MODE_DATA, 16'd2250);
		send_item(MODE_DATA, 16'hFFFF);
		send_item(MODE_DATA, ZERO_MAX_RST);
		send_item(MODE_END, 16'h0000);
		send_item(MODE_LEADER, 16'd9000);
		send_item(MODE_DATA, SPACE_MAX_RST);        // space on the bound: miss
		send_item(MODE_DATA, 16'd1200);
		send_item(MODE_END, 16'h0000);
		send_item(MODE_LEADER, 16'd9049);
		send_item(MODE_DATA, 16'd4401);
		send_item(MODE_DATA, 16'd2299);
		send_item(MODE_DATA, 16'd1101);
		send_item(MODE_DATA, 16'd0000);
		send_item(MODE_END, 16'h5555);

		run_items(PHASE_ITEMS);

		// random NEC-like windows, no idling, long result stall
		c.zero_min = 16'($urandom_range(0, 2000));
		c.zero_max = c.zero_min + 16'($urandom_range(2, 500));
		c.one_min = c.zero_max + 16'($urandom_range(0, 500));
		c.one_max = c.one_min + 16'($urandom_range(2, 500));
		c.space_min = c.one_max + 16'($urandom_range(0, 1000));
		c.space_max = c.space_min + 16'($urandom_range(2, 1000));
		c.leader_min = c.space_max + 16'($urandom_range(0, 1000));
		c.leader_max = c.leader_min + 16'($urandom_range(2, 1000));
		program_windows(c);
		tx_idle = 0;
		rx_idle = 0;
		rx_hold_req = 1;
		run_items(PHASE_ITEMS);

		// all windows wide open: zero wins wherever a bit window matches
		c = '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF};
		program_windows(c);
		rx_idle = 1;
		run_items(PHASE_ITEMS);

		// all windows closed
		c = '{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0};
		program_windows(c);
		tx_idle = 1;
		run_items(PHASE_ITEMS);

		// overlapping bit windows
		c = '{LEADER_MIN_RST, LEADER_MAX_RST, 16'd0, 16'hFFFF,
			16'd1000, 16'd3000, 16'd2000, 16'd4000};
		program_windows(c);
		rx_idle = 0;
		rx_hold_req = 1;
		run_items(PHASE_ITEMS);

		c = '{LEADER_MIN_RST, LEADER_MAX_RST, SPACE_MIN_RST, SPACE_MAX_RST,
			ZERO_MIN_RST, ZERO_MAX_RST, ONE_MIN_RST, ONE_MAX_RST};
		program_windows(c);
		rx_idle = 1;
		run_items(PHASE_ITEMS);

		settle();
		repeat (10) @(negedge clk);
		if (trk.errors == 0 && trk.frames_due.size() == 0)
			$display("nec_ir_frame_decoder: match");
		else
			$display("nec_ir_frame_decoder: mismatch");
		$finish;
	end

endmodule
